### rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/drrq_pkg.sv
// ============================================================================
// drrq_pkg
// Types, widths and codes shared by the deduplicating ring queue modules.
// ============================================================================
`default_nettype none

package drrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_BITS    = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int REQ_W       = 2;
    localparam int KEY_FIELD_W = 32;
    localparam int HANDLE_W    = 32;
    localparam int STATUS_W    = 3;
    localparam int OCC_W       = 5;

    localparam int S_TDATA_W   = ((KEY_FIELD_W + HANDLE_W + 7) / 8) * 8;
    localparam int OCC_LSB     = KEY_FIELD_W + HANDLE_W;
    localparam int M_USED_W    = OCC_LSB + OCC_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REQUEUE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY       = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP         = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DROPPED     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_OVERWRITTEN = 3'd4;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/drrq_ctrl.sv
// ============================================================================
// drrq_ctrl
// Request sequencer: capture a word, then execute it once the result
// register can take the outcome.
// ============================================================================
`default_nettype none

module drrq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire drrq_pkg::dp_status_t stat,
    output drrq_pkg::dp_cmd_t         cmd
);
    import drrq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_EXEC:
            begin
                cmd.commit = !stat.out_stall;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/drrq_dp.sv
// ============================================================================
// drrq_dp
// Ring storage, head and count registers, parallel key compare and the
// result register.
// ============================================================================
`default_nettype none

module drrq_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire drrq_pkg::dp_cmd_t              cmd,
    output drrq_pkg::dp_status_t                stat,
    input  wire logic [drrq_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [drrq_pkg::REQ_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [drrq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [drrq_pkg::STATUS_W-1:0]       m_tuser
);
    import drrq_pkg::*;

    logic [KEY_BITS-1:0]    key_mem [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]    pay_mem [QUEUE_DEPTH];

    logic [REQ_W-1:0]       req_type_reg;
    logic [KEY_BITS-1:0]    req_key_reg;
    logic [HANDLE_W-1:0]    req_pay_reg;
    logic [KEY_BITS-1:0]    rd_key_reg;
    logic [HANDLE_W-1:0]    rd_pay_reg;

    logic [IDX_W-1:0]       head_reg;
    logic [IDX_W-1:0]       head_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [STATUS_W-1:0]    out_status_next;
    logic [KEY_FIELD_W-1:0] out_key_reg;
    logic [KEY_FIELD_W-1:0] out_key_next;
    logic [HANDLE_W-1:0]    out_pay_reg;
    logic [HANDLE_W-1:0]    out_pay_next;

    logic [IDX_W:0]         offset    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] hit;
    logic                   dup;
    logic                   full;
    logic                   empty;
    logic [IDX_W:0]         tail_sum;
    logic [IDX_W-1:0]       tail_idx;
    logic [IDX_W-1:0]       head_inc;
    logic [IDX_W-1:0]       head_dec;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if ({1'b0, IDX_W'(i)} >= {1'b0, head_reg})
            begin
                offset[i] = {1'b0, IDX_W'(i)} - {1'b0, head_reg};
            end
            else
            begin
                offset[i] = {1'b0, IDX_W'(i)} + (IDX_W + 1)'(QUEUE_DEPTH) - {1'b0, head_reg};
            end
            hit[i] = (CNT_W'(offset[i]) < count_reg) && (key_mem[i] == req_key_reg);
        end
    end

    assign dup   = |hit;
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        tail_sum = {1'b0, head_reg} + (IDX_W + 1)'(count_reg);
        if (tail_sum >= (IDX_W + 1)'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        tail_idx = tail_sum[IDX_W-1:0];
        head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_reg - 1'b1;
    end

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        out_status_next = STAT_OK;
        out_key_next    = '0;
        out_pay_next    = '0;
        wr_en           = 1'b0;
        wr_idx          = tail_idx;
        unique case (req_type_reg)
            REQ_PUSH:
            begin
                if (dup)
                begin
                    out_status_next = STAT_DUP;
                end
                else if (!full)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_idx          = head_reg;
                    head_next       = head_inc;
                    out_status_next = STAT_DROPPED;
                end
            end
            REQ_POP:
            begin
                if (empty)
                begin
                    out_status_next = STAT_EMPTY;
                end
                else
                begin
                    out_key_next = KEY_FIELD_W'(rd_key_reg);
                    out_pay_next = rd_pay_reg;
                    head_next    = head_inc;
                    count_next   = count_reg - 1'b1;
                end
            end
            REQ_REQUEUE:
            begin
                wr_en     = 1'b1;
                wr_idx    = head_dec;
                head_next = head_dec;
                if (!full)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    out_status_next = STAT_OVERWRITTEN;
                end
            end
            default:
            begin
                out_status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= s_tuser;
            req_key_reg  <= s_tdata[KEY_BITS-1:0];
            req_pay_reg  <= s_tdata[KEY_FIELD_W +: HANDLE_W];
        end
        rd_key_reg <= key_mem[head_reg];
        rd_pay_reg <= pay_mem[head_reg];
        if (cmd.commit && wr_en)
        begin
            key_mem[wr_idx] <= req_key_reg;
            pay_mem[wr_idx] <= req_pay_reg;
        end
        if (cmd.commit)
        begin
            out_status_reg <= out_status_next;
            out_key_reg    <= out_key_next;
            out_pay_reg    <= out_pay_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_stall = out_valid_reg && !m_tready;
    assign m_tvalid       = out_valid_reg;
    assign m_tuser        = out_status_reg;
    assign m_tdata        = {(M_TDATA_W - M_USED_W)'(0), OCC_W'(count_reg), out_pay_reg,
                             out_key_reg};

endmodule

`default_nettype wire

### rtl/dedup_retry_ring_queue.sv
// ============================================================================
// dedup_retry_ring_queue
// Ring queue of tasks with duplicate-key rejection on push, pop of the
// oldest task and requeue at the front.
// ============================================================================
//
//   Channel  Direction  Word contents (lowest bit first)
//   s_*      in         tuser: req_type; tdata: entry_key, payload_handle
//   m_*      out        tuser: status; tdata: out_key, out_payload, occupancy
//
// Each request is handled in turn: first the word is captured, then its key is
// compared against all sixteen slots in parallel and the ring is updated.
// The result register lets the next word be captured while a result waits;
// execution holds while that register is full and m_tready is low.
// Reset clears head, count and the result valid; the slot contents are not
// cleared and are only read once written.
`default_nettype none

module dedup_retry_ring_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_key [31:0], payload_handle [63:32]
    input  wire logic [drrq_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type [1:0]
    input  wire logic [drrq_pkg::REQ_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_key [31:0], out_payload [63:32], occupancy [68:64], zero pad above
    output logic [drrq_pkg::M_TDATA_W-1:0]      m_tdata,
    // status [2:0]
    output logic [drrq_pkg::STATUS_W-1:0]       m_tuser
);
    import drrq_pkg::*;

    `include "assert_macros.svh"

    dp_cmd_t    cmd;
    dp_status_t stat;
    logic       occ_over;
    logic       stray_data;

    drrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    drrq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign occ_over   = (m_tdata[OCC_LSB +: OCC_W] > OCC_W'(QUEUE_DEPTH));
    assign stray_data = (m_tuser != STAT_OK) && (|m_tdata[OCC_LSB-1:0]);

    `ASSERT_CLK(a_one_word_in_flight, (s_tvalid && s_tready) |=> !s_tready, "accepted while busy")
    `ASSERT_NEVER(a_occ_bound, m_tvalid && occ_over, "occupancy above depth")
    `ASSERT_NEVER(a_data_only_on_pop, m_tvalid && stray_data, "entry data with non-ok status")

endmodule

`default_nettype wire

### sim/dedup_retry_ring_queue_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// dedup_retry_ring_queue_tb
// Self-checking testbench for the deduplicating ring queue with requeue.
// Requests go in on the slave stream and results come back on the master
// stream. Each accepted request is run through a model of the ring that the
// testbench keeps itself. The model's expected result is queued and compared
// field by field with the next result word. The stimulus covers the corner
// cases, repeated fill, drop and drain rounds, a long receiver hold-off, and
// a random mix with random idle gaps on both sides.
// ============================================================================

module dedup_retry_ring_queue_tb;

    import drrq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [KEY_FIELD_W-1:0] key;
        logic [HANDLE_W-1:0]    payload;
        logic [OCC_W-1:0]       occ;
    } ring_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    logic [KEY_FIELD_W-1:0] key_ring [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]    handle_ring [QUEUE_DEPTH];
    logic [IDX_W-1:0]       ring_head  = '0;
    logic [OCC_W-1:0]       ring_count = '0;
    ring_result_t           pending_results [$];
    logic [KEY_FIELD_W-1:0] key_pool [24];

    bit tx_gaps     = 1'b1;
    bit rx_stalls   = 1'b1;
    int rx_hold_len = 0;

    int mismatch_count = 0;
    int n_requests     = 0;
    int n_stored       = 0;
    int n_dups         = 0;
    int n_dropped      = 0;
    int n_overwritten  = 0;
    int n_popped       = 0;
    int n_empty        = 0;
    int max_fill       = 0;

    dedup_retry_ring_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // Updates the ring image for one accepted request and queues its result.
    task automatic apply_request(input logic [REQ_W-1:0] req,
                                 input logic [KEY_FIELD_W-1:0] key,
                                 input logic [HANDLE_W-1:0] pay);
        ring_result_t     r;
        logic             hit;
        logic [IDX_W-1:0] slot;
        int               i;
        r.status  = STAT_OK;
        r.key     = '0;
        r.payload = '0;
        case (req)
            REQ_PUSH:
            begin
                hit  = 1'b0;
                slot = ring_head;
                for (i = 0; i < ring_count; i++)
                begin
                    if (key_ring[slot] == key)
                        hit = 1'b1;
                    slot = slot + 1'b1;
                end
                if (hit)
                begin
                    r.status = STAT_DUP;
                    n_dups++;
                end
                else
                begin
                    if (ring_count < QUEUE_DEPTH)
                    begin
                        slot       = ring_head + ring_count[IDX_W-1:0];
                        ring_count = ring_count + 1'b1;
                    end
                    else
                    begin
                        slot      = ring_head;
                        ring_head = ring_head + 1'b1;
                        r.status  = STAT_DROPPED;
                        n_dropped++;
                    end
                    key_ring[slot]    = key;
                    handle_ring[slot] = pay;
                    n_stored++;
                end
            end
            REQ_POP:
            begin
                if (ring_count == 0)
                begin
                    r.status = STAT_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.key      = key_ring[ring_head];
                    r.payload  = handle_ring[ring_head];
                    ring_head  = ring_head + 1'b1;
                    ring_count = ring_count - 1'b1;
                    n_popped++;
                end
            end
            REQ_REQUEUE:
            begin
                ring_head = ring_head - 1'b1;
                if (ring_count < QUEUE_DEPTH)
                    ring_count = ring_count + 1'b1;
                else
                begin
                    r.status = STAT_OVERWRITTEN;
                    n_overwritten++;
                end
                key_ring[ring_head]    = key;
                handle_ring[ring_head] = pay;
            end
            default:
            begin
            end
        endcase
        r.occ = ring_count;
        if (ring_count > max_fill)
            max_fill = ring_count;
        n_requests++;
        pending_results.push_back(r);
    endtask

    // Offers one word on the slave stream; called at a rising edge.
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [KEY_FIELD_W-1:0] key,
                                input logic [HANDLE_W-1:0] pay);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {pay, key};
        do
            @(posedge clk);
        while (!s_tready);
        apply_request(req, key, pay);
    endtask

    function automatic logic [KEY_FIELD_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, 23)];
        return $urandom;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic send_random_request(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            send_request(REQ_UNUSED, $urandom, $urandom);
        else if (r < 2 + push_pct)
            send_request(REQ_PUSH, pick_key(), pick_payload());
        else if (r < 14 + push_pct)
            send_request(REQ_REQUEUE, pick_key(), pick_payload());
        else
            send_request(REQ_POP, $urandom, $urandom);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic test_directed_corners();
        send_request(REQ_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_REQUEUE, 32'h0000_0001, 32'h0000_0002);
        send_request(REQ_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_PUSH, 32'h0000_0000, 32'h1234_5678);
        send_request(REQ_REQUEUE, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_request(REQ_UNUSED, 32'h0000_0000, 32'h0000_0000);
        repeat (5) send_request(REQ_POP, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_full_ring();
        int round;
        for (round = 0; round < 3; round++)
        begin
            while (ring_count < QUEUE_DEPTH)
                send_request(REQ_PUSH, pick_key(), pick_payload());
            repeat (3) send_request(REQ_PUSH, $urandom, pick_payload());
            send_request(REQ_PUSH, key_ring[ring_head], pick_payload());
            repeat (2) send_request(REQ_REQUEUE, pick_key(), pick_payload());
            while (ring_count > 0)
                send_request(REQ_POP, $urandom, $urandom);
            send_request(REQ_POP, $urandom, $urandom);
        end
    endtask

    task automatic test_backpressure();
        tx_gaps     = 1'b0;
        rx_hold_len = 300;
        repeat (40) send_random_request(70);
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_mix();
        int chunk;
        int push_pct;
        for (chunk = 0; chunk < 10; chunk++)
        begin
            case (chunk % 3)
                0:       push_pct = 80;
                1:       push_pct = 50;
                default: push_pct = 25;
            endcase
            tx_gaps   = (chunk % 4 != 3) && ($urandom_range(0, 3) != 0);
            rx_stalls = (chunk % 4 != 3) && ($urandom_range(0, 3) != 0);
            repeat (23) send_random_request(push_pct);
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // Result side: random stalls per word, a long hold-off on request.
    initial
    begin
        int           stall_next;
        int           hold;
        ring_result_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        stall_next = 0;
        forever
        begin
            if (rx_hold_len > 0)
            begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            if (stall_next > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_next) @(posedge clk);
                stall_next = 0;
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, expected none, actual status %0d",
                             $time, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("out_key", want.key, m_tdata[KEY_FIELD_W-1:0]);
                    check_field("out_payload", want.payload,
                                m_tdata[KEY_FIELD_W +: HANDLE_W]);
                    check_field("occupancy", want.occ, m_tdata[OCC_LSB +: OCC_W]);
                end
                stall_next = rx_stalls ? $urandom_range(0, 17) : 0;
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < 24; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_full_ring();
        test_backpressure();
        test_random_mix();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d requests: %0d stored, %0d duplicates, %0d oldest dropped,",
                 n_requests, n_stored, n_dups, n_dropped);
        $display("%0d overwritten on requeue, %0d popped, %0d empty pops, peak fill %0d.",
                 n_overwritten, n_popped, n_empty, max_fill);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
